FILE: design/smtr_pkg.sv
// shared constants, types and helpers of the shadow map triangle rasterizer
package smtr_pkg;

    // map geometry
    localparam int MAP_WIDTH   = 256;
    localparam int MAP_HEIGHT  = 256;
    localparam int NUM_MAPS    = 3;
    localparam int MAP_PIXELS  = MAP_WIDTH * MAP_HEIGHT;
    localparam int STORE_DEPTH = NUM_MAPS * MAP_PIXELS;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int DW          = 32;

    // internal number formats
    localparam int XW     = 20;   // signed span column
    localparam int ACCW   = 34;   // signed Q18.16 edge accumulator
    localparam int SLW    = 26;   // signed Q10.16 column slope
    localparam int ZSW    = 34;   // signed depth slope
    localparam int ZW     = 44;   // signed interpolated depth
    localparam int DIV_NW = 44;   // divider dividend and quotient
    localparam int DIV_DW = 20;   // divider divisor and remainder

    // queue between front and back
    localparam int Q_DEPTH = 2;

    localparam logic signed [XW-1:0] X_LIMIT   = XW'(MAP_WIDTH);
    localparam logic [DW-1:0]        DEPTH_MAX = '1;

    typedef enum logic {
        OP_RASTER = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    // one classified item as it travels from front to back
    typedef struct packed {
        t_op                  op;
        logic [1:0]           map;
        logic                 rd_zero;
        logic [AW-1:0]        rd_addr;
        logic [2:0][7:0]      x;
        logic [2:0][7:0]      y;
        logic [2:0][DW-1:0]   z;
        logic                 orient_neg;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [DW-1:0] wr_data;
        logic          rd_en;
        logic [AW-1:0] rd_addr;
    } t_ram_req;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_TRI_START,
        S_SLOPE_DIV,
        S_SLOPE_WAIT,
        S_HALF_INIT,
        S_ROW,
        S_SPAN_WAIT,
        S_SPAN_PIX,
        S_ROW_NEXT
    } t_bstate;

    // Q18.16 to integer column, truncated toward zero
    function automatic logic signed [XW-1:0] trunc_q16(input logic signed [ACCW-1:0] a);
        logic signed [ACCW-17:0] s;
        s = a[ACCW-1:16];
        if (a[ACCW-1] && (a[15:0] != 16'h0)) begin
            s = s + 1'b1;
        end
        return XW'(s);
    endfunction

endpackage

FILE: design/smtr_ram.sv
// generic single write port, single read port ram with registered read
module smtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: design/smtr_front.sv
// front end: accepts items, sorts vertices by row and classifies the work
module smtr_front (
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_operation,
    input  logic [1:0]          i_map_select,
    input  logic [7:0]          i_vert0_x,
    input  logic [7:0]          i_vert0_y,
    input  logic [31:0]         i_vert0_depth,
    input  logic [7:0]          i_vert1_x,
    input  logic [7:0]          i_vert1_y,
    input  logic [31:0]         i_vert1_depth,
    input  logic [7:0]          i_vert2_x,
    input  logic [7:0]          i_vert2_y,
    input  logic [31:0]         i_vert2_depth,
    input  logic [15:0]         i_read_pixel,
    input  logic                i_full,
    input  logic                i_clearing,
    output logic                o_push,
    output smtr_pkg::t_item     o_item
);
    import smtr_pkg::*;

    logic [7:0]         sx [3];
    logic [7:0]         sy [3];
    logic [DW-1:0]      sz [3];
    logic [7:0]         tx;
    logic [7:0]         ty;
    logic [DW-1:0]      tz;
    logic signed [8:0]  w_dx0;
    logic signed [8:0]  w_dx2;
    logic signed [8:0]  w_dy0;
    logic signed [8:0]  w_dy2;
    logic signed [18:0] w_orient;
    logic               w_map_ok;
    logic               w_pix_ok;
    logic               w_flat;
    logic               w_accept;
    logic               w_is_read;

    // exchange sort of the vertices by row, fixed pass order
    always_comb begin
        sx[0] = i_vert0_x;  sy[0] = i_vert0_y;  sz[0] = i_vert0_depth;
        sx[1] = i_vert1_x;  sy[1] = i_vert1_y;  sz[1] = i_vert1_depth;
        sx[2] = i_vert2_x;  sy[2] = i_vert2_y;  sz[2] = i_vert2_depth;
        tx = '0;
        ty = '0;
        tz = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (sy[i] < sy[j]) begin
                    tx = sx[j];  ty = sy[j];  tz = sz[j];
                    sx[j] = sx[i];  sy[j] = sy[i];  sz[j] = sz[i];
                    sx[i] = tx;  sy[i] = ty;  sz[i] = tz;
                end
            end
        end
    end

    // winding from the sorted vertices
    assign w_dx0    = $signed({1'b0, sx[1]}) - $signed({1'b0, sx[0]});
    assign w_dy0    = $signed({1'b0, sy[1]}) - $signed({1'b0, sy[0]});
    assign w_dx2    = $signed({1'b0, sx[0]}) - $signed({1'b0, sx[2]});
    assign w_dy2    = $signed({1'b0, sy[0]}) - $signed({1'b0, sy[2]});
    assign w_orient = 19'(w_dx0 * w_dy2) - 19'(w_dy0 * w_dx2);

    // classification
    assign w_is_read = (t_op'(i_operation) == OP_READ);
    assign w_map_ok  = (int'(i_map_select) < NUM_MAPS);
    assign w_pix_ok  = (int'(i_read_pixel) < MAP_PIXELS);
    assign w_flat    = (sy[0] == sy[1]) && (sy[1] == sy[2]);

    assign o_stall  = i_full || i_clearing;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = w_accept && (w_is_read || (w_map_ok && !w_flat));

    // item to the queue
    always_comb begin
        o_item            = '0;
        o_item.op         = t_op'(i_operation);
        o_item.map        = i_map_select;
        o_item.rd_zero    = !(w_map_ok && w_pix_ok);
        o_item.rd_addr    = AW'(int'(i_map_select) * MAP_PIXELS + int'(i_read_pixel));
        o_item.orient_neg = w_orient[18];
        for (int k = 0; k < 3; k++) begin
            o_item.x[k] = sx[k];
            o_item.y[k] = sy[k];
            o_item.z[k] = sz[k];
        end
    end
endmodule

FILE: design/smtr_queue.sv
// short item queue between the front end and the back end
module smtr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  smtr_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output smtr_pkg::t_item  o_item
);
    import smtr_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_item            r_mem [Q_DEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QCW-1:0]   r_count;
    logic             w_push;
    logic             w_pop;

    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_full  = (r_count == QCW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QAW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end
endmodule

FILE: design/smtr_div.sv
// shared radix-2 restoring divider, one quotient bit per cycle
module smtr_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smtr_pkg::t_div_req  i_req,
    output smtr_pkg::t_div_rsp  o_rsp
);
    import smtr_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [DIV_NW-1:0]   r_quo;
    logic [DIV_DW-1:0]   r_rem;
    logic [DIV_DW-1:0]   r_den;
    logic [DIV_DW:0]     w_part;
    logic [DIV_NW-1:0]   n_quo;
    logic [DIV_DW-1:0]   n_rem;

    // one trial subtraction
    always_comb begin
        w_part = {r_rem, r_quo[DIV_NW-1]};
        if (w_part >= {1'b0, r_den}) begin
            n_rem = DIV_DW'(w_part - {1'b0, r_den});
            n_quo = {r_quo[DIV_NW-2:0], 1'b1};
        end else begin
            n_rem = w_part[DIV_DW-1:0];
            n_quo = {r_quo[DIV_NW-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule

FILE: design/smtr_back.sv
// back end: clears the store, walks edges and spans, depth tests pixels, serves reads
module smtr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  smtr_pkg::t_item     i_item,
    output logic                o_pop,
    output logic                o_clearing,
    output smtr_pkg::t_div_req  o_div_req,
    input  smtr_pkg::t_div_rsp  i_div_rsp,
    output smtr_pkg::t_ram_req  o_ram_req,
    input  logic [31:0]         i_rd_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_depth_value
);
    import smtr_pkg::*;

    t_bstate                  r_state, n_state;
    t_item                    r_tri, n_tri;
    logic                     r_half, n_half;
    logic                     r_div_long, n_div_long;
    logic                     r_div_z, n_div_z;
    logic signed [SLW-1:0]    r_s_long, n_s_long, r_s_short, n_s_short;
    logic signed [ZSW-1:0]    r_z_long, n_z_long, r_z_short, n_z_short;
    logic signed [SLW-1:0]    r_sa, n_sa, r_sb, n_sb;
    logic signed [ZSW-1:0]    r_za, n_za, r_zb, n_zb;
    logic signed [ACCW-1:0]   r_acc_a, n_acc_a, r_acc_b, n_acc_b;
    logic signed [ZW-1:0]     r_za_acc, n_za_acc, r_zb_acc, n_zb_acc;
    logic [7:0]               r_row, n_row, r_row_end, n_row_end;
    logic [AW-1:0]            r_base, n_base;
    logic signed [XW-1:0]     r_x, n_x, r_xb, n_xb;
    logic [DIV_DW-1:0]        r_len, n_len;
    logic signed [ZW-1:0]     r_z1, n_z1;
    logic                     r_dneg, n_dneg;
    logic [DIV_NW-1:0]        r_q, n_q, r_q_step, n_q_step;
    logic [DIV_DW-1:0]        r_r, n_r, r_r_step, n_r_step;
    logic                     r_wb_valid, n_wb_valid;
    logic [AW-1:0]            r_wb_addr, n_wb_addr;
    logic [DW-1:0]            r_wb_depth, n_wb_depth;
    logic                     r_out_valid, n_out_valid;
    logic [DW-1:0]            r_out_data, n_out_data;
    logic [AW-1:0]            r_clr_addr, n_clr_addr;

    logic signed [8:0]        w_dx0, w_dx1, w_dx2, w_dy0, w_dy1, w_dy2;
    logic signed [32:0]       w_dz0, w_dz1, w_dz2;
    logic signed [8:0]        w_e_dx, w_e_dy;
    logic signed [32:0]       w_e_dz;
    logic [7:0]               w_dx_mag, w_dy_mag;
    logic [31:0]              w_dz_mag;
    logic                     w_q_neg;
    logic [DIV_NW-1:0]        w_slope_num;
    logic signed [DIV_NW:0]   w_q_signed;
    logic signed [SLW-1:0]    w_sa, w_sb;
    logic signed [ZSW-1:0]    w_za, w_zb;
    logic signed [9:0]        w_t;
    logic signed [SLW+9:0]    w_pa, w_pb;
    logic signed [ZSW+9:0]    w_pza, w_pzb;
    logic [7:0]               w_anc_x;
    logic [DW-1:0]            w_anc_z;
    logic signed [ACCW-1:0]   w_anc_acc;
    logic signed [ZW-1:0]     w_anc_zs;
    logic signed [XW-1:0]     w_xa, w_xb, w_len, w_x_next;
    logic signed [ZW-1:0]     w_dspan;
    logic [DIV_NW-1:0]        w_dspan_mag;
    logic                     w_skip;
    logic signed [ZW:0]       w_d;
    logic [DW-1:0]            w_d_sat;
    logic [DIV_DW:0]          w_r_sum;
    logic                     w_carry;

    // edge differences of the sorted triangle
    assign w_dx0 = $signed({1'b0, r_tri.x[1]}) - $signed({1'b0, r_tri.x[0]});
    assign w_dx1 = $signed({1'b0, r_tri.x[2]}) - $signed({1'b0, r_tri.x[1]});
    assign w_dx2 = $signed({1'b0, r_tri.x[0]}) - $signed({1'b0, r_tri.x[2]});
    assign w_dy0 = $signed({1'b0, r_tri.y[1]}) - $signed({1'b0, r_tri.y[0]});
    assign w_dy1 = $signed({1'b0, r_tri.y[2]}) - $signed({1'b0, r_tri.y[1]});
    assign w_dy2 = $signed({1'b0, r_tri.y[0]}) - $signed({1'b0, r_tri.y[2]});
    assign w_dz0 = $signed({1'b0, r_tri.z[1]}) - $signed({1'b0, r_tri.z[0]});
    assign w_dz1 = $signed({1'b0, r_tri.z[2]}) - $signed({1'b0, r_tri.z[1]});
    assign w_dz2 = $signed({1'b0, r_tri.z[0]}) - $signed({1'b0, r_tri.z[2]});

    // operands of the slope division: long edge, or the short edge of this half
    assign w_e_dx = r_div_long ? w_dx2 : (r_half ? w_dx1 : w_dx0);
    assign w_e_dy = r_div_long ? w_dy2 : (r_half ? w_dy1 : w_dy0);
    assign w_e_dz = r_div_long ? w_dz2 : (r_half ? w_dz1 : w_dz0);
    assign w_dx_mag    = w_e_dx[8] ? 8'(-w_e_dx) : w_e_dx[7:0];
    assign w_dy_mag    = w_e_dy[8] ? 8'(-w_e_dy) : w_e_dy[7:0];
    assign w_dz_mag    = w_e_dz[32] ? 32'(-w_e_dz) : w_e_dz[31:0];
    assign w_slope_num = r_div_z ? DIV_NW'(w_dz_mag) : DIV_NW'({w_dx_mag, 16'h0});
    assign w_q_neg     = (r_div_z ? w_e_dz[32] : w_e_dx[8]) ^ w_e_dy[8];
    assign w_q_signed  = w_q_neg ? -$signed({1'b0, i_div_rsp.quo})
                                 : $signed({1'b0, i_div_rsp.quo});

    // left and right edge slopes after the winding swap
    assign w_sa = r_tri.orient_neg ? r_s_long  : r_s_short;
    assign w_sb = r_tri.orient_neg ? r_s_short : r_s_long;
    assign w_za = r_tri.orient_neg ? r_z_long  : r_z_short;
    assign w_zb = r_tri.orient_neg ? r_z_short : r_z_long;

    // half start: offset from the anchor vertex is zero on top, minus dy1 below
    assign w_t       = r_half ? -$signed({1'b0, w_dy1}) : 10'sd0;
    assign w_pa      = w_sa * w_t;
    assign w_pb      = w_sb * w_t;
    assign w_pza     = w_za * w_t;
    assign w_pzb     = w_zb * w_t;
    assign w_anc_x   = r_half ? r_tri.x[2] : r_tri.x[0];
    assign w_anc_z   = r_half ? r_tri.z[2] : r_tri.z[0];
    assign w_anc_acc = $signed(ACCW'({w_anc_x, 16'h0}));
    assign w_anc_zs  = $signed(ZW'(w_anc_z));

    // span ends and depth difference of the current row
    assign w_xa        = trunc_q16(r_acc_a);
    assign w_xb        = trunc_q16(r_acc_b);
    assign w_len       = w_xb - w_xa;
    assign w_dspan     = r_zb_acc - r_za_acc;
    assign w_dspan_mag = w_dspan[ZW-1] ? DIV_NW'(-w_dspan) : DIV_NW'(w_dspan);
    assign w_skip      = (int'(r_row) >= MAP_HEIGHT) || (w_xb <= w_xa)
                         || (w_xa >= X_LIMIT) || (w_xb <= 0);

    // pixel depth and saturation
    assign w_d = $signed({r_z1[ZW-1], r_z1})
                 + (r_dneg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q}));
    always_comb begin
        if (w_d[ZW]) begin
            w_d_sat = '0;
        end else if (|w_d[ZW-1:DW]) begin
            w_d_sat = DEPTH_MAX;
        end else begin
            w_d_sat = w_d[DW-1:0];
        end
    end

    // fractional step of the depth quotient
    assign w_r_sum  = {1'b0, r_r} + {1'b0, r_r_step};
    assign w_carry  = (w_r_sum >= {1'b0, r_len});
    assign w_x_next = r_x + 1'b1;

    // next state, datapath and port controls
    always_comb begin
        n_state     = r_state;
        n_tri       = r_tri;
        n_half      = r_half;
        n_div_long  = r_div_long;
        n_div_z     = r_div_z;
        n_s_long    = r_s_long;
        n_s_short   = r_s_short;
        n_z_long    = r_z_long;
        n_z_short   = r_z_short;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_za        = r_za;
        n_zb        = r_zb;
        n_acc_a     = r_acc_a;
        n_acc_b     = r_acc_b;
        n_za_acc    = r_za_acc;
        n_zb_acc    = r_zb_acc;
        n_row       = r_row;
        n_row_end   = r_row_end;
        n_base      = r_base;
        n_x         = r_x;
        n_xb        = r_xb;
        n_len       = r_len;
        n_z1        = r_z1;
        n_dneg      = r_dneg;
        n_q         = r_q;
        n_q_step    = r_q_step;
        n_r         = r_r;
        n_r_step    = r_r_step;
        n_wb_valid  = 1'b0;
        n_wb_addr   = r_wb_addr;
        n_wb_depth  = r_wb_depth;
        n_out_valid = r_out_valid && i_stall;
        n_out_data  = r_out_data;
        n_clr_addr  = r_clr_addr;

        o_pop             = 1'b0;
        o_div_req         = '0;
        o_ram_req         = '0;
        o_ram_req.wr_en   = r_wb_valid && (r_wb_depth > i_rd_data);
        o_ram_req.wr_addr = r_wb_addr;
        o_ram_req.wr_data = r_wb_depth;

        case (r_state)
            S_CLEAR: begin
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_addr = r_clr_addr;
                o_ram_req.wr_data = '0;
                n_clr_addr        = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_tri = i_item;
                    n_state = (i_item.op == OP_READ) ? S_RD_ISSUE : S_TRI_START;
                end
            end
            S_RD_ISSUE: begin
                if (!r_out_valid) begin
                    if (r_tri.rd_zero) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_state     = S_IDLE;
                    end else begin
                        o_ram_req.rd_en   = 1'b1;
                        o_ram_req.rd_addr = r_tri.rd_addr;
                        n_state           = S_RD_WAIT;
                    end
                end
            end
            S_RD_WAIT: begin
                n_out_valid = 1'b1;
                n_out_data  = i_rd_data;
                n_state     = S_IDLE;
            end
            S_TRI_START: begin
                n_half     = (w_dy0 == 9'sd0);
                n_div_long = 1'b1;
                n_div_z    = 1'b0;
                n_state    = S_SLOPE_DIV;
            end
            S_SLOPE_DIV: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = w_slope_num;
                o_div_req.den   = DIV_DW'(w_dy_mag);
                n_state         = S_SLOPE_WAIT;
            end
            S_SLOPE_WAIT: begin
                if (i_div_rsp.done) begin
                    case ({r_div_long, r_div_z})
                        2'b10:   n_s_long  = SLW'(w_q_signed);
                        2'b11:   n_z_long  = ZSW'(w_q_signed);
                        2'b00:   n_s_short = SLW'(w_q_signed);
                        default: n_z_short = ZSW'(w_q_signed);
                    endcase
                    if (!r_div_z) begin
                        n_div_z = 1'b1;
                        n_state = S_SLOPE_DIV;
                    end else if (r_div_long) begin
                        n_div_long = 1'b0;
                        n_div_z    = 1'b0;
                        n_state    = S_SLOPE_DIV;
                    end else begin
                        n_state = S_HALF_INIT;
                    end
                end
            end
            S_HALF_INIT: begin
                n_sa      = w_sa;
                n_sb      = w_sb;
                n_za      = w_za;
                n_zb      = w_zb;
                n_acc_a   = w_anc_acc + ACCW'(w_pa);
                n_acc_b   = w_anc_acc + ACCW'(w_pb);
                n_za_acc  = w_anc_zs + ZW'(w_pza);
                n_zb_acc  = w_anc_zs + ZW'(w_pzb);
                n_row     = r_half ? r_tri.y[1] : r_tri.y[0];
                n_row_end = r_half ? r_tri.y[2] : r_tri.y[1];
                n_state   = S_ROW;
            end
            S_ROW: begin
                n_base = AW'(int'(r_tri.map) * MAP_PIXELS + int'(r_row) * MAP_WIDTH);
                if (w_skip) begin
                    n_state = S_ROW_NEXT;
                end else begin
                    o_div_req.start = 1'b1;
                    o_div_req.num   = w_dspan_mag;
                    o_div_req.den   = DIV_DW'(w_len);
                    n_x             = w_xa;
                    n_xb            = w_xb;
                    n_len           = DIV_DW'(w_len);
                    n_z1            = r_za_acc;
                    n_dneg          = w_dspan[ZW-1];
                    n_state         = S_SPAN_WAIT;
                end
            end
            S_SPAN_WAIT: begin
                if (i_div_rsp.done) begin
                    n_q_step = i_div_rsp.quo;
                    n_r_step = i_div_rsp.rem;
                    n_q      = '0;
                    n_r      = '0;
                    n_state  = S_SPAN_PIX;
                end
            end
            S_SPAN_PIX: begin
                // read now, compare and write back next cycle
                if (!r_x[XW-1]) begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = r_base + AW'(r_x);
                    n_wb_valid        = 1'b1;
                    n_wb_addr         = r_base + AW'(r_x);
                    n_wb_depth        = w_d_sat;
                end
                n_x = w_x_next;
                n_q = r_q + r_q_step + DIV_NW'(w_carry);
                n_r = w_carry ? DIV_DW'(w_r_sum - {1'b0, r_len}) : w_r_sum[DIV_DW-1:0];
                if ((w_x_next == r_xb) || (w_x_next >= X_LIMIT)) begin
                    n_state = S_ROW_NEXT;
                end
            end
            S_ROW_NEXT: begin
                n_acc_a  = r_acc_a + ACCW'(r_sa);
                n_acc_b  = r_acc_b + ACCW'(r_sb);
                n_za_acc = r_za_acc + ZW'(r_za);
                n_zb_acc = r_zb_acc + ZW'(r_zb);
                n_row    = r_row + 1'b1;
                if ({1'b0, r_row} + 9'd1 == {1'b0, r_row_end}) begin
                    if (!r_half && (w_dy1 != 9'sd0)) begin
                        n_half     = 1'b1;
                        n_div_long = 1'b0;
                        n_div_z    = 1'b0;
                        n_state    = S_SLOPE_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_ROW;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_wb_valid  <= n_wb_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_tri      <= n_tri;
        r_half     <= n_half;
        r_div_long <= n_div_long;
        r_div_z    <= n_div_z;
        r_s_long   <= n_s_long;
        r_s_short  <= n_s_short;
        r_z_long   <= n_z_long;
        r_z_short  <= n_z_short;
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_za       <= n_za;
        r_zb       <= n_zb;
        r_acc_a    <= n_acc_a;
        r_acc_b    <= n_acc_b;
        r_za_acc   <= n_za_acc;
        r_zb_acc   <= n_zb_acc;
        r_row      <= n_row;
        r_row_end  <= n_row_end;
        r_base     <= n_base;
        r_x        <= n_x;
        r_xb       <= n_xb;
        r_len      <= n_len;
        r_z1       <= n_z1;
        r_dneg     <= n_dneg;
        r_q        <= n_q;
        r_q_step   <= n_q_step;
        r_r        <= n_r;
        r_r_step   <= n_r_step;
        r_wb_addr  <= n_wb_addr;
        r_wb_depth <= n_wb_depth;
        r_out_data <= n_out_data;
    end

    assign o_clearing    = (r_state == S_CLEAR);
    assign o_valid       = r_out_valid;
    assign o_depth_value = r_out_data;

    // no result leaves while the store is being cleared
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result shown during store clear");

    // a depth write-back always follows a pixel read
    a_wb_after_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid |-> ($past(r_state) == S_SPAN_PIX))
        else $error("write-back without a pixel read");

    // span walk stays left of the excluded right end
    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPAN_PIX) |-> (r_x < r_xb))
        else $error("span column past its end");

    // depth interpolation remainder stays below the span length
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPAN_PIX) |-> (r_r < r_len))
        else $error("span remainder out of range");
endmodule

FILE: design/shadow_map_triangle_rasterizer_top.sv
// top level of the shadow map triangle rasterizer with its depth store
// read: accepted into the queue, then served by the back end through a store read (skipped
//   when it reads as zero); items are carried out one at a time in order
// triangle: four slope divisions on the shared divider before the first row, two more before
//   a bottom half; per row a span division, then each column walked reads the depth store
//   and writes back a greater depth; a row with no span is skipped
// reset: synchronous, active low; a clearing pass over all NUM_MAPS * MAP_PIXELS entries
module shadow_map_triangle_rasterizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [1:0]  i_map_select,
    input  logic [7:0]  i_vert0_x,
    input  logic [7:0]  i_vert0_y,
    input  logic [31:0] i_vert0_depth,
    input  logic [7:0]  i_vert1_x,
    input  logic [7:0]  i_vert1_y,
    input  logic [31:0] i_vert1_depth,
    input  logic [7:0]  i_vert2_x,
    input  logic [7:0]  i_vert2_y,
    input  logic [31:0] i_vert2_depth,
    input  logic [15:0] i_read_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_depth_value
);
    import smtr_pkg::*;

    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    logic       w_clearing;
    t_item      w_front_item;
    t_item      w_head_item;
    t_div_req   w_div_req;
    t_div_rsp   w_div_rsp;
    t_ram_req   w_ram_req;
    logic [DW-1:0] w_rd_data;

    // item intake and classification
    smtr_front u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_map_select  (i_map_select),
        .i_vert0_x     (i_vert0_x),
        .i_vert0_y     (i_vert0_y),
        .i_vert0_depth (i_vert0_depth),
        .i_vert1_x     (i_vert1_x),
        .i_vert1_y     (i_vert1_y),
        .i_vert1_depth (i_vert1_depth),
        .i_vert2_x     (i_vert2_x),
        .i_vert2_y     (i_vert2_y),
        .i_vert2_depth (i_vert2_depth),
        .i_read_pixel  (i_read_pixel),
        .i_full        (w_full),
        .i_clearing    (w_clearing),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    // decoupling queue
    smtr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_head_item)
    );

    // shared divider
    smtr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // rasterizer and read engine
    smtr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_item        (w_head_item),
        .o_pop         (w_pop),
        .o_clearing    (w_clearing),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp),
        .o_ram_req     (w_ram_req),
        .i_rd_data     (w_rd_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_depth_value (o_depth_value)
    );

    // depth store, all cascade maps back to back
    smtr_ram #(
        .WIDTH (DW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_req.wr_en),
        .i_wr_addr (w_ram_req.wr_addr),
        .i_wr_data (w_ram_req.wr_data),
        .i_rd_en   (w_ram_req.rd_en),
        .i_rd_addr (w_ram_req.rd_addr),
        .o_rd_data (w_rd_data)
    );
endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for the shadow map triangle rasterizer top level
module tb_top;
    import smtr_pkg::*;

    localparam int  HALF_PERIOD = 10;
    localparam int  RESET_CYCLES = 9;
    localparam int  RANDOM_ITEMS = 1150;
    localparam int  MAX_REPORTS = 10;
    localparam int  HOLD_OFF = 3000;
    localparam int  DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 6000000;

    // one stimulus item, with an optional typed-in depth to expect
    typedef struct {
        t_op             op;
        logic [1:0]      map;
        logic [2:0][7:0] vx;
        logic [2:0][7:0] vy;
        logic [2:0][31:0] vz;
        logic [15:0]     pix;
        bit              fixed;
        logic [31:0]     want;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = 1'b0;
    logic [1:0]  i_map_select = '0;
    logic [7:0]  i_vert0_x = '0;
    logic [7:0]  i_vert0_y = '0;
    logic [31:0] i_vert0_depth = '0;
    logic [7:0]  i_vert1_x = '0;
    logic [7:0]  i_vert1_y = '0;
    logic [31:0] i_vert1_depth = '0;
    logic [7:0]  i_vert2_x = '0;
    logic [7:0]  i_vert2_y = '0;
    logic [31:0] i_vert2_depth = '0;
    logic [15:0] i_read_pixel = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_depth_value;

    // shadow copy of the depth maps and the reads still owed
    bit [31:0]   depth_map [0:STORE_DEPTH-1];
    logic [31:0] depth_due [$];
    bit          cur_fixed = 1'b0;
    logic [31:0] cur_want = '0;
    int          mismatches = 0;
    int          hold_cycles = 0;
    longint      cycles = 0;
    int          bx_lo = 0, bx_hi = 0, by_lo = 0, by_hi = 0;

    shadow_map_triangle_rasterizer_top DUT (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    // one span of a row, right end excluded, strictly-greater depth update
    task automatic plot_span(input int m, input longint row, input longint xa, input longint xb,
                             input longint z1, input longint z2);
        longint len, d;
        len = xb - xa;
        for (longint x = xa; x < xb; x++) begin
            d = z1 + ((z2 - z1) * (x - xa)) / len;
            if (d < 0) d = 0;
            if (d > 64'sh0FFFF_FFFF) d = 64'sh0FFFF_FFFF;
            if (x < 0 || x >= MAP_WIDTH || row < 0 || row >= MAP_HEIGHT) continue;
            if (d[31:0] > depth_map[m * MAP_PIXELS + row * MAP_WIDTH + x])
                depth_map[m * MAP_PIXELS + row * MAP_WIDTH + x] = d[31:0];
        end
    endtask

    task automatic fill_half(input int m, input longint y_from, input longint y_to,
                             input longint t0, input longint sa, input longint sb,
                             input longint za, input longint zb, input longint ax,
                             input longint az);
        longint t;
        t = t0;
        for (longint row = y_from; row < y_to; row++) begin
            plot_span(m, row, (ax * 65536 + sa * t) / 65536, (ax * 65536 + sb * t) / 65536,
                      az + za * t, az + zb * t);
            t++;
        end
    endtask

    // draws one triangle into the shadow maps
    task automatic rasterize(input logic [1:0] m, input logic [2:0][7:0] px,
                             input logic [2:0][7:0] py, input logic [2:0][31:0] pz);
        longint x[3], y[3], z[3], ys[3], orient, sa, sb, za, zb, tmp, dx0, dx1, dx2;
        longint dy0, dy1, dy2, dz0, dz1, dz2, tl;
        int ord[3], k;
        if (m >= NUM_MAPS) return;
        for (int i = 0; i < 3; i++) begin
            ys[i] = py[i];
            ord[i] = i;
        end
        // exchange sort by row, ties settle as the sort leaves them
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (ys[i] < ys[j]) begin
                    k = ord[j]; tl = ys[j];
                    ord[j] = ord[i]; ys[j] = ys[i];
                    ord[i] = k; ys[i] = tl;
                end
        for (int i = 0; i < 3; i++) begin
            x[i] = px[ord[i]];
            y[i] = py[ord[i]];
            z[i] = pz[ord[i]];
        end
        dx0 = x[1] - x[0]; dx1 = x[2] - x[1]; dx2 = x[0] - x[2];
        dy0 = y[1] - y[0]; dy1 = y[2] - y[1]; dy2 = y[0] - y[2];
        dz0 = z[1] - z[0]; dz1 = z[2] - z[1]; dz2 = z[0] - z[2];
        orient = dx0 * dy2 - dy0 * dx2;
        // top half
        if (dy0 != 0) begin
            sa = (dx0 * 65536) / dy0; sb = (dx2 * 65536) / dy2;
            za = dz0 / dy0; zb = dz2 / dy2;
            if (orient < 0) begin
                tmp = sa; sa = sb; sb = tmp;
                tmp = za; za = zb; zb = tmp;
            end
            fill_half(m, y[0], y[1], 0, sa, sb, za, zb, x[0], z[0]);
        end
        // bottom half, anchored on the last vertex
        if (dy1 == 0) return;
        sa = (dx1 * 65536) / dy1; sb = (dx2 * 65536) / dy2;
        za = dz1 / dy1; zb = dz2 / dy2;
        if (orient < 0) begin
            tmp = sa; sa = sb; sb = tmp;
            tmp = za; za = zb; zb = tmp;
        end
        fill_half(m, y[1], y[2], -dy1, sa, sb, za, zb, x[2], z[2]);
    endtask

    function automatic t_stim read_item(input logic [1:0] m, input logic [15:0] p,
                                        input bit fixed, input logic [31:0] want);
        t_stim s;
        s = '{op: OP_READ, map: m, vx: '0, vy: '0, vz: '0, pix: p, fixed: fixed, want: want};
        return s;
    endfunction

    function automatic t_stim raster_item(input logic [1:0] m,
                                          input int x0, input int y0, input logic [31:0] z0,
                                          input int x1, input int y1, input logic [31:0] z1,
                                          input int x2, input int y2, input logic [31:0] z2);
        t_stim s;
        s.op = OP_RASTER; s.map = m; s.pix = '0; s.fixed = 1'b0; s.want = '0;
        s.vx = {8'(x2), 8'(x1), 8'(x0)};
        s.vy = {8'(y2), 8'(y1), 8'(y0)};
        s.vz = {z2, z1, z0};
        return s;
    endfunction

    // cycle count and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // result check first, then prediction for the item taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (depth_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected depth result %h", o_depth_value);
            end else begin
                if (o_depth_value !== depth_due[0]) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("depth_value mismatch: expected %h actual %h",
                                 depth_due[0], o_depth_value);
                end
                void'(depth_due.pop_front());
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            if (i_operation == OP_READ) begin
                if (cur_fixed)
                    depth_due.push_back(cur_want);
                else if (i_map_select < NUM_MAPS)
                    depth_due.push_back(depth_map[i_map_select * MAP_PIXELS + i_read_pixel]);
                else
                    depth_due.push_back('0);
            end else begin
                rasterize(i_map_select, {i_vert2_x, i_vert1_x, i_vert0_x},
                          {i_vert2_y, i_vert1_y, i_vert0_y},
                          {i_vert2_depth, i_vert1_depth, i_vert0_depth});
            end
        end
    end

    // receiver stalls in modes that change every so often, plus one long hold-off
    initial begin
        int mode, left;
        mode = 0; left = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall = 1'b1;
            end else begin
                case (mode)
                    0: i_stall = 1'b0;
                    1: i_stall = ($urandom_range(0, 9) < 3);
                    2: i_stall = ($urandom_range(0, 9) < 7);
                    default: i_stall = ~i_stall;
                endcase
            end
        end
    end

    int burst_left = 0;

    // offers one item and waits for it to be taken, then maybe a gap
    task automatic send(input t_stim s);
        int gap;
        @(negedge i_clk);
        i_operation = s.op; i_map_select = s.map; i_read_pixel = s.pix;
        i_vert0_x = s.vx[0]; i_vert0_y = s.vy[0]; i_vert0_depth = s.vz[0];
        i_vert1_x = s.vx[1]; i_vert1_y = s.vy[1]; i_vert1_depth = s.vz[1];
        i_vert2_x = s.vx[2]; i_vert2_y = s.vy[2]; i_vert2_depth = s.vz[2];
        cur_fixed = s.fixed; cur_want = s.want;
        i_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 25);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > 255) ? 255 : v;
    endfunction

    // random triangle, mostly small, around a random centre, bounding box kept for reads
    function automatic t_stim random_triangle();
        t_stim s;
        int cx, cy, sz, xs[3], ys[3];
        logic [31:0] zbase;
        cx = $urandom_range(0, 255); cy = $urandom_range(0, 255);
        sz = ($urandom_range(0, 49) == 0) ? 120 : $urandom_range(2, 18);
        zbase = $urandom;
        s.op = OP_RASTER; s.pix = '0; s.fixed = 1'b0; s.want = '0;
        s.map = ($urandom_range(0, 11) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        bx_lo = 255; bx_hi = 0; by_lo = 255; by_hi = 0;
        for (int i = 0; i < 3; i++) begin
            xs[i] = clamp_coord(cx + $urandom_range(0, 2 * sz) - sz);
            ys[i] = clamp_coord(cy + $urandom_range(0, 2 * sz) - sz);
            if ($urandom_range(0, 9) == 0) ys[i] = ys[0];
            s.vx[i] = 8'(xs[i]); s.vy[i] = 8'(ys[i]);
            s.vz[i] = ($urandom_range(0, 2) == 0) ? $urandom : zbase + $urandom_range(0, 65535);
            if (xs[i] < bx_lo) bx_lo = xs[i];
            if (xs[i] > bx_hi) bx_hi = xs[i];
            if (ys[i] < by_lo) by_lo = ys[i];
            if (ys[i] > by_hi) by_hi = ys[i];
        end
        return s;
    endfunction

    function automatic t_stim random_read(input logic [1:0] last_map);
        logic [15:0] p;
        logic [1:0] m;
        if ($urandom_range(0, 3) != 0) begin
            p = 16'($urandom_range(by_lo, by_hi) * MAP_WIDTH + $urandom_range(bx_lo, bx_hi));
            m = last_map;
        end else begin
            p = 16'($urandom);
            m = 2'($urandom_range(0, 3));
        end
        return read_item(m, p, 1'b0, '0);
    endfunction

    t_stim directed [$];

    initial begin
        t_stim s;
        logic [1:0] last_map;
        // directed: empty store, map extremes, big and degenerate triangles
        directed.push_back(read_item(2'd0, 16'h0000, 1'b1, 32'h0));
        directed.push_back(read_item(2'd2, 16'hFFFF, 1'b1, 32'h0));
        directed.push_back(read_item(2'd3, 16'h1234, 1'b1, 32'h0));
        directed.push_back(raster_item(2'd0, 0, 0, 32'hFFFF_FFFF, 255, 0, 32'hFFFF_FFFF,
                                       0, 255, 32'hFFFF_FFFF));
        directed.push_back(read_item(2'd0, 16'h0000, 1'b0, '0));
        directed.push_back(read_item(2'd0, 16'h1010, 1'b0, '0));
        directed.push_back(raster_item(2'd2, 255, 255, 32'h0, 0, 255, 32'hFFFF_FFFF,
                                       255, 0, 32'h8000_0000));
        directed.push_back(read_item(2'd2, 16'hFEFE, 1'b0, '0));
        directed.push_back(read_item(2'd2, 16'hFFFF, 1'b0, '0));
        directed.push_back(raster_item(2'd3, 10, 10, 32'hFFFF_FFFF, 40, 10, 32'hFFFF_FFFF,
                                       20, 40, 32'hFFFF_FFFF));
        directed.push_back(read_item(2'd3, 16'h0F14, 1'b1, 32'h0));
        directed.push_back(raster_item(2'd1, 10, 20, 32'h0100_0000, 40, 20, 32'h0200_0000,
                                       25, 50, 32'h0300_0000));
        directed.push_back(raster_item(2'd1, 60, 20, 32'h0400_0000, 70, 50, 32'h0500_0000,
                                       90, 50, 32'h0600_0000));
        directed.push_back(raster_item(2'd1, 100, 30, 32'h0700_0000, 30, 30, 32'h0700_0000,
                                       60, 30, 32'h0700_0000));
        directed.push_back(raster_item(2'd1, 120, 10, 32'h0F00_0000, 140, 40, 32'h0100_0000,
                                       100, 40, 32'h00FF_FFFF));
        directed.push_back(raster_item(2'd1, 100, 40, 32'h00FF_FFFF, 140, 40, 32'h0100_0000,
                                       120, 10, 32'h0F00_0000));
        directed.push_back(raster_item(2'd1, 10, 20, 32'h0100_0000, 40, 20, 32'h0200_0000,
                                       25, 50, 32'h0300_0000));
        directed.push_back(raster_item(2'd1, 50, 60, 32'h0, 50, 60, 32'h0, 50, 60, 32'h0));
        directed.push_back(read_item(2'd1, 16'd30 * 256 + 16'd25, 1'b0, '0));
        directed.push_back(read_item(2'd1, 16'd40 * 256 + 16'd75, 1'b0, '0));
        directed.push_back(read_item(2'd1, 16'd30 * 256 + 16'd120, 1'b0, '0));
        directed.push_back(read_item(2'd1, 16'd30 * 256 + 16'd80, 1'b0, '0));

        // reset once
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[n]) send(directed[n]);

        // random part opens with a long receiver hold-off under a stream of reads
        hold_cycles = HOLD_OFF;
        last_map = 2'd1;
        bx_lo = 10; bx_hi = 140; by_lo = 10; by_hi = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n < 40 || $urandom_range(0, 9) < 6) begin
                s = random_read(last_map);
            end else begin
                s = random_triangle();
                last_map = (s.map < NUM_MAPS) ? s.map : 2'd0;
            end
            send(s);
        end
        // closing read so that all drawing is done before the drain
        send(read_item(2'd0, 16'h0000, 1'b0, '0));
        @(negedge i_clk);
        i_valid = 1'b0;

        // drain
        while (depth_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
